// ===== src/cnfs_pkg.sv =====
// ---------------------------------------------------------------------------
// cnfs_pkg: shared types and constants for the cron next-fire search
// Calendar constants, month length table, register indexes, sequencer states.
// ---------------------------------------------------------------------------
package cnfs_pkg;

   localparam int unsigned SCAN_LIMIT_DEF = 40000;

   localparam int unsigned NOW_W      = 32;
   localparam int unsigned DELAY_W    = 32;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 60;

   localparam int unsigned MS_PER_MIN    = 60000;
   localparam int unsigned MIN_PER_HOUR  = 60;
   localparam int unsigned MIN_PER_DAY   = 24 * 60;
   localparam int unsigned BASE_DOW      = 4;

   // minute number of a 32-bit ms timestamp fits in 17 bits
   localparam int unsigned BASE_W = 17;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MINUTE_MASK = 3'd0,
      REG_HOUR_MASK   = 3'd1,
      REG_DOM_MASK    = 3'd2,
      REG_MONTH_MASK  = 3'd3,
      REG_DOW_MASK    = 3'd4,
      REG_RULE_VALID  = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_DAYS,
      ST_HOURS,
      ST_MINS,
      ST_SCAN,
      ST_FIN
   } seq_state_type;

   typedef enum logic [1:0] {
      STEP_NONE,
      STEP_DAY,
      STEP_HOUR,
      STEP_MIN
   } step_type;

   typedef struct packed {
      logic     clear;
      step_type step;
   } cal_cmd_type;

   function automatic logic [4:0] month_len(input logic [3:0] month);
      logic [4:0] len;
      case (month)
         4'd2:    len = 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ===== src/cnfs_div.sv =====
// ---------------------------------------------------------------------------
// cnfs_div: timestamp to minute number
// Divides by ms per minute through a reciprocal multiply; operand, then product registered.
// ---------------------------------------------------------------------------
module cnfs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cnfs_pkg::NOW_W-1:0]    dividend,
   output logic                          done,
   output logic [cnfs_pkg::BASE_W-1:0]   quotient
);
   import cnfs_pkg::*;

   // 60000 = 32 * 1875: drop five low bits, then multiply by ceil(2^38 / 1875);
   // the rounding error stays below 2^11, exact for every 27-bit operand
   localparam int unsigned     PRE_SHIFT = 5;
   localparam int unsigned     X_W       = NOW_W - PRE_SHIFT;
   localparam int unsigned     M_W       = 28;
   localparam int unsigned     P_W       = X_W + M_W;
   localparam int unsigned     Q_SHIFT   = 38;
   localparam logic [M_W-1:0]  RECIP     = 28'd146601551;

   logic              pend_ff, pend_in;
   logic              done_ff, done_in;
   logic [X_W-1:0]    x_ff, x_in;
   logic [P_W-1:0]    prod_ff, prod_in;

   always_comb begin
      pend_in = start;
      done_in = pend_ff;
      x_in    = start ? dividend[NOW_W-1:PRE_SHIFT] : x_ff;
      prod_in = pend_ff ? ({{M_W{1'b0}}, x_ff} * {{X_W{1'b0}}, RECIP}) : prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      prod_ff <= prod_in;
   end

   assign done     = done_ff;
   assign quotient = prod_ff[Q_SHIFT +: BASE_W];

endmodule

// ===== src/cnfs_cal.sv =====
// ---------------------------------------------------------------------------
// cnfs_cal: incremental calendar counters and mask match
// Steps by one day, hour or minute with carries; flags a matching minute.
// ---------------------------------------------------------------------------
module cnfs_cal (
   input  logic                  clock,
   input  cnfs_pkg::cal_cmd_type cmd,
   input  logic [59:0]           minute_mask,
   input  logic [23:0]           hour_mask,
   input  logic [31:0]           dom_mask,
   input  logic [12:0]           month_mask,
   input  logic [6:0]            dow_mask,
   output logic                  hit
);
   import cnfs_pkg::*;

   logic [5:0] minute_ff, minute_in;
   logic [4:0] hour_ff, hour_in;
   logic [4:0] dom_ff, dom_in;
   logic [3:0] month_ff, month_in;
   logic [2:0] dow_ff, dow_in;
   logic       past_ff, past_in;   // beyond the last day of the year
   logic       day_carry, hour_carry;

   logic [63:0] minute_bits;
   logic [31:0] hour_bits;
   logic [15:0] month_bits;
   logic [7:0]  dow_bits;

   always_comb begin
      minute_in  = minute_ff;
      hour_in    = hour_ff;
      dom_in     = dom_ff;
      month_in   = month_ff;
      dow_in     = dow_ff;
      past_in    = past_ff;
      hour_carry = 1'b0;
      day_carry  = 1'b0;

      case (cmd.step)
         STEP_MIN: begin
            if (minute_ff == 6'(MIN_PER_HOUR - 1)) begin
               minute_in  = '0;
               hour_carry = 1'b1;
            end else begin
               minute_in = minute_ff + 1'b1;
            end
         end
         STEP_HOUR: hour_carry = 1'b1;
         STEP_DAY:  day_carry  = 1'b1;
         default: ;
      endcase

      if (hour_carry) begin
         if (hour_ff == 5'd23) begin
            hour_in   = '0;
            day_carry = 1'b1;
         end else begin
            hour_in = hour_ff + 1'b1;
         end
      end

      if (day_carry) begin
         dow_in = (dow_ff == 3'd6) ? 3'd0 : dow_ff + 1'b1;
         if (!past_ff) begin
            if (dom_ff == month_len(month_ff)) begin
               dom_in = 5'd1;
               if (month_ff == 4'd12) begin
                  // past the year end the date sticks at the first of January
                  month_in = 4'd1;
                  past_in  = 1'b1;
               end else begin
                  month_in = month_ff + 1'b1;
               end
            end else begin
               dom_in = dom_ff + 1'b1;
            end
         end
      end

      if (cmd.clear) begin
         minute_in = '0;
         hour_in   = '0;
         dom_in    = 5'd1;
         month_in  = 4'd1;
         dow_in    = 3'(BASE_DOW);
         past_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      minute_ff <= minute_in;
      hour_ff   <= hour_in;
      dom_ff    <= dom_in;
      month_ff  <= month_in;
      dow_ff    <= dow_in;
      past_ff   <= past_in;
   end

   assign minute_bits = {4'b0, minute_mask};
   assign hour_bits   = {8'b0, hour_mask};
   assign month_bits  = {3'b0, month_mask};
   assign dow_bits    = {1'b0, dow_mask};

   assign hit = minute_bits[minute_ff] & hour_bits[hour_ff] & month_bits[month_ff]
              & (dom_mask[dom_ff] | dow_bits[dow_ff]);

endmodule

// ===== src/cron_next_fire_search.sv =====
// ---------------------------------------------------------------------------
// cron_next_fire_search: first cron-matching minute at or after a timestamp
// Divides the timestamp into a minute number, fast-forwards a calendar to it,
// then walks forward one minute per cycle testing the cron masks.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake          | content
//  --------+-----------+--------------------+--------------------------------
//  req_    | in        | tvalid/tready      | tdata: now_ms
//  rsp_    | out       | tvalid/tready      | tdata: wait_ms, tuser: found
//  csr_    | in        | we, no back-press. | index + wdata, register write
//
// Per request: accept, divide, fast-forward by days, then hours, then minutes,
//   then scan minutes (up to SCAN_LIMIT) and finish.
//   The minute scan through the shared calendar counter dominates.
// An invalid rule skips the search and goes straight from idle to the finish state.
// req_tready is high only while idle; a finished result waits in the output
//   register, and the next result stalls until rsp_tready frees it.
// Reset is synchronous; it clears control state and all cron registers.
// ---------------------------------------------------------------------------
module cron_next_fire_search #(
   parameter int unsigned SCAN_LIMIT = cnfs_pkg::SCAN_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cnfs_pkg::NOW_W-1:0]        req_tdata,   // [31:0] now_ms
   // response
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cnfs_pkg::DELAY_W-1:0]      rsp_tdata,   // [31:0] wait_ms
   output logic                              rsp_tuser,   // [0] found
   // configuration
   input  logic                              csr_we,
   input  logic [cnfs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cnfs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cnfs_pkg::*;

   localparam int unsigned D_W = $clog2(SCAN_LIMIT + 1);

   // cron registers
   logic [59:0] minute_mask_ff;
   logic [23:0] hour_mask_ff;
   logic [31:0] dom_mask_ff;
   logic [12:0] month_mask_ff;
   logic [6:0]  dow_mask_ff;
   logic        rule_valid_ff;

   seq_state_type          state_ff, state_in;
   logic [BASE_W-1:0]      rem_ff, rem_in;      // minutes still to fast-forward
   logic [D_W-1:0]         scan_ff, scan_in;    // minutes ahead of the base
   logic [DELAY_W-1:0]     delay_ff, delay_in;  // scan_ff * 60000, kept as a sum
   logic                   found_ff, found_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [DELAY_W-1:0]     rsp_delay_ff, rsp_delay_in;

   logic                   div_start, div_done;
   logic [BASE_W-1:0]      div_quo;
   cal_cmd_type            cal_cmd;
   logic                   cal_hit;

   // one subtractor serves all fast-forward phases; the borrow is the compare
   logic [BASE_W-1:0]      step_amt;
   logic [BASE_W:0]        rem_diff;
   logic                   rem_ge;

   // csr writes; unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         minute_mask_ff <= '0;
         hour_mask_ff   <= '0;
         dom_mask_ff    <= '0;
         month_mask_ff  <= '0;
         dow_mask_ff    <= '0;
         rule_valid_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MINUTE_MASK: minute_mask_ff <= csr_wdata[59:0];
            REG_HOUR_MASK:   hour_mask_ff   <= csr_wdata[23:0];
            REG_DOM_MASK:    dom_mask_ff    <= csr_wdata[31:0];
            REG_MONTH_MASK:  month_mask_ff  <= csr_wdata[12:0];
            REG_DOW_MASK:    dow_mask_ff    <= csr_wdata[6:0];
            REG_RULE_VALID:  rule_valid_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   cnfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata),
      .done     (div_done),
      .quotient (div_quo)
   );

   cnfs_cal u_cal (
      .clock       (clock),
      .cmd         (cal_cmd),
      .minute_mask (minute_mask_ff),
      .hour_mask   (hour_mask_ff),
      .dom_mask    (dom_mask_ff),
      .month_mask  (month_mask_ff),
      .dow_mask    (dow_mask_ff),
      .hit         (cal_hit)
   );

   always_comb begin
      case (state_ff)
         ST_DAYS:  step_amt = BASE_W'(MIN_PER_DAY);
         ST_HOURS: step_amt = BASE_W'(MIN_PER_HOUR);
         default:  step_amt = BASE_W'(1);
      endcase
   end

   assign rem_diff = {1'b0, rem_ff} - {1'b0, step_amt};
   assign rem_ge   = ~rem_diff[BASE_W];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      scan_in      = scan_ff;
      delay_in     = delay_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_delay_in = rsp_delay_ff;
      div_start    = 1'b0;
      cal_cmd      = '{clear: 1'b0, step: STEP_NONE};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cal_cmd.clear = 1'b1;
               scan_in       = '0;
               delay_in      = '0;
               found_in      = 1'b0;
               if (rule_valid_ff) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rem_in   = div_quo;
               state_in = ST_DAYS;
            end
         end
         ST_DAYS, ST_HOURS, ST_MINS: begin
            if (rem_ge) begin
               rem_in = rem_diff[BASE_W-1:0];
               case (state_ff)
                  ST_DAYS:  cal_cmd.step = STEP_DAY;
                  ST_HOURS: cal_cmd.step = STEP_HOUR;
                  default:  cal_cmd.step = STEP_MIN;
               endcase
            end else begin
               case (state_ff)
                  ST_DAYS:  state_in = ST_HOURS;
                  ST_HOURS: state_in = ST_MINS;
                  default:  state_in = ST_SCAN;
               endcase
            end
         end
         ST_SCAN: begin
            if (cal_hit) begin
               found_in = 1'b1;
               state_in = ST_FIN;
            end else if (scan_ff == D_W'(SCAN_LIMIT - 1)) begin
               state_in = ST_FIN;
            end else begin
               cal_cmd.step = STEP_MIN;
               scan_in      = scan_ff + 1'b1;
               delay_in     = delay_ff + DELAY_W'(MS_PER_MIN);
            end
         end
         ST_FIN: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_delay_in = found_ff ? delay_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff       <= rem_in;
      scan_ff      <= scan_in;
      delay_ff     <= delay_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
      rsp_delay_ff <= rsp_delay_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_delay_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule

// ===== src/cnfs_checker.sv =====
// ---------------------------------------------------------------------------
// cnfs_checker: port-level checks for the cron next-fire search
// Watches the request and response channels and the reset.
// ---------------------------------------------------------------------------
module cnfs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [cnfs_pkg::DELAY_W-1:0]  rsp_tdata,
   input logic                          rsp_tuser
);
   import cnfs_pkg::*;

   // a stalled response keeps its content
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // no match means zero delay
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("delay nonzero without a match");

   // delays are whole minutes, so always a multiple of 32 ms
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[4:0] == 5'd0)
      else $error("delay not a whole number of minutes");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after a request was taken");

   // reset empties the output
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind cron_next_fire_search cnfs_checker u_cnfs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
